[hw/rtl/rspt_pkg.sv]
// shared types, codes and helpers for the range sign product tree
// no dependencies; used by rspt_cfg, rspt_engine and range_sign_product_tree

package rspt_pkg;

    // sign codes held in each tree node
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // command codes carried in tuser
    localparam logic CMD_CHANGE  = 1'b0;
    localparam logic CMD_PRODUCT = 1'b1;

    // register map
    localparam int unsigned ELEM_W        = 11;
    localparam logic        REG_ELEMENTS  = 1'b0;
    localparam logic [ELEM_W-1:0] ELEMENTS_RESET = 11'd1024;

    // field widths
    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 8;

    // one input beat, unpacked
    typedef struct packed {
        logic                    cmd;
        logic [POS_W-1:0]        first;
        logic [POS_W-1:0]        last;
        logic signed [VAL_W-1:0] value;
    } t_item;

    // engine sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_WR,
        ST_UPD_CMB,
        ST_Q_L,
        ST_Q_LD,
        ST_Q_R,
        ST_Q_RD,
        ST_DONE
    } t_state;

    // sign code of a stored value
    function automatic logic [1:0] sign_of(input logic signed [VAL_W-1:0] v);
        logic [1:0] s;
        if (v == '0) begin
            s = SIGN_ZERO;
        end else if (v[VAL_W-1]) begin
            s = SIGN_NEG;
        end else begin
            s = SIGN_POS;
        end
        return s;
    endfunction

    // sign of the product of two signs
    function automatic logic [1:0] sign_combine(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] s;
        if (a == SIGN_ZERO || b == SIGN_ZERO) begin
            s = SIGN_ZERO;
        end else if (a == b) begin
            s = SIGN_POS;
        end else begin
            s = SIGN_NEG;
        end
        return s;
    endfunction

endpackage

[hw/rtl/rspt_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies

module rspt_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rspt_cfg.sv]
// apb register block holding the elements_in_use register
// depends on rspt_pkg

module rspt_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready,
    output logic [rspt_pkg::ELEM_W-1:0] o_elements
);

    logic [rspt_pkg::ELEM_W-1:0] r_elements;
    logic                        w_wr;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && (i_paddr[2] == rspt_pkg::REG_ELEMENTS);

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elements <= rspt_pkg::ELEMENTS_RESET;
        end else if (w_wr) begin
            r_elements <= i_pwdata[rspt_pkg::ELEM_W-1:0];
        end
    end

    // read mux
    always_comb begin
        if (i_paddr[2] == rspt_pkg::REG_ELEMENTS) begin
            o_prdata = {{(32 - rspt_pkg::ELEM_W){1'b0}}, r_elements};
        end else begin
            o_prdata = '0;
        end
    end

    assign o_elements = r_elements;

endmodule

[hw/rtl/rspt_engine.sv]
// tree walk sequencer: clearing sweep, leaf change with ancestor rebuild,
// and bottom-up range product over the node ram; depends on rspt_pkg

module rspt_engine #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [rspt_pkg::ELEM_W-1:0]           i_elements,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  rspt_pkg::t_item                       i_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_out_sign,
    output logic                                  o_out_err,
    output logic                                  o_ram_we,
    output logic [$clog2(2*MAX_ELEMENTS)-1:0]     o_ram_waddr,
    output logic [1:0]                            o_ram_wdata,
    output logic [$clog2(2*MAX_ELEMENTS)-1:0]     o_ram_raddr,
    input  logic [1:0]                            i_ram_rdata
);

    // node index width, walk pointer width (holds 2*MAX), count width
    localparam int unsigned IW  = $clog2(2*MAX_ELEMENTS);
    localparam int unsigned LW  = $clog2(2*MAX_ELEMENTS + 1);
    localparam int unsigned NW  = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW  = (NW > rspt_pkg::ELEM_W) ? NW : rspt_pkg::ELEM_W;
    localparam logic [IW-1:0] LAST_NODE = IW'(2*MAX_ELEMENTS - 1);
    localparam logic [LW-1:0] LEAF_BASE = LW'(MAX_ELEMENTS);
    localparam logic [AW-1:0] MAX_CNT   = AW'(MAX_ELEMENTS);

    rspt_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_p, n_p;
    logic [1:0]    r_val, n_val;
    logic [LW-1:0] r_l, n_l;
    logic [LW-1:0] r_r, n_r;
    logic [1:0]    r_acc, n_acc;
    logic          r_err, n_err;
    logic          r_out_valid;
    logic [1:0]    r_out_sign;
    logic          r_out_err;

    logic [AW-1:0] w_active;
    logic [AW-1:0] w_elem_ext;
    logic          w_accept;
    logic          w_chg_ok;
    logic          w_q_bad;
    logic          w_out_free;

    // active element count, clamped to the tree size
    assign w_elem_ext = AW'(i_elements);
    assign w_active   = (w_elem_ext > MAX_CNT) ? MAX_CNT : w_elem_ext;

    // command decode at acceptance
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_chg_ok   = (AW'(i_item.first) < w_active);
    assign w_q_bad    = (i_item.first > i_item.last) || (AW'(i_item.last) >= w_active);
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rspt_pkg::ST_CLEAR: begin
                if (r_clr == LAST_NODE) begin
                    n_state = rspt_pkg::ST_IDLE;
                end
            end
            rspt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.cmd == rspt_pkg::CMD_CHANGE) begin
                        if (w_chg_ok) begin
                            n_state = rspt_pkg::ST_UPD_WR;
                        end
                    end else if (w_q_bad) begin
                        n_state = rspt_pkg::ST_DONE;
                    end else begin
                        n_state = rspt_pkg::ST_Q_L;
                    end
                end
            end
            rspt_pkg::ST_UPD_WR: begin
                if (r_p == LW'(1)) begin
                    n_state = rspt_pkg::ST_IDLE;
                end else begin
                    n_state = rspt_pkg::ST_UPD_CMB;
                end
            end
            rspt_pkg::ST_UPD_CMB: n_state = rspt_pkg::ST_UPD_WR;
            rspt_pkg::ST_Q_L: begin
                if (!(r_l < r_r)) begin
                    n_state = rspt_pkg::ST_DONE;
                end else if (r_l[0]) begin
                    n_state = rspt_pkg::ST_Q_LD;
                end else begin
                    n_state = rspt_pkg::ST_Q_R;
                end
            end
            rspt_pkg::ST_Q_LD: n_state = rspt_pkg::ST_Q_R;
            rspt_pkg::ST_Q_R: begin
                if (r_r[0]) begin
                    n_state = rspt_pkg::ST_Q_RD;
                end else begin
                    n_state = rspt_pkg::ST_Q_L;
                end
            end
            rspt_pkg::ST_Q_RD: n_state = rspt_pkg::ST_Q_L;
            rspt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = rspt_pkg::ST_IDLE;
                end
            end
            default: n_state = rspt_pkg::ST_IDLE;
        endcase
    end

    // ram port and handshake outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_clr;
        o_ram_wdata = rspt_pkg::SIGN_ZERO;
        o_ram_raddr = '0;
        unique case (r_state)
            rspt_pkg::ST_CLEAR: begin
                o_ram_we = 1'b1;
            end
            rspt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            rspt_pkg::ST_UPD_WR: begin
                // write this node and fetch its sibling in the same cycle
                o_ram_we    = 1'b1;
                o_ram_waddr = r_p[IW-1:0];
                o_ram_wdata = r_val;
                o_ram_raddr = r_p[IW-1:0] ^ IW'(1);
            end
            rspt_pkg::ST_Q_L: begin
                o_ram_raddr = r_l[IW-1:0];
            end
            rspt_pkg::ST_Q_R: begin
                o_ram_raddr = r_r[IW-1:0] - IW'(1);
            end
            rspt_pkg::ST_UPD_CMB, rspt_pkg::ST_Q_LD, rspt_pkg::ST_Q_RD,
            rspt_pkg::ST_DONE: begin
                o_ram_raddr = '0;
            end
            default: begin
                o_ram_we = 1'b0;
            end
        endcase
    end

    // walk datapath
    always_comb begin
        n_clr = r_clr;
        n_p   = r_p;
        n_val = r_val;
        n_l   = r_l;
        n_r   = r_r;
        n_acc = r_acc;
        n_err = r_err;
        case (r_state)
            rspt_pkg::ST_CLEAR: begin
                n_clr = r_clr + IW'(1);
            end
            rspt_pkg::ST_IDLE: begin
                n_p   = LEAF_BASE + LW'(i_item.first);
                n_val = rspt_pkg::sign_of(i_item.value);
                n_l   = LEAF_BASE + LW'(i_item.first);
                n_r   = LEAF_BASE + LW'(i_item.last) + LW'(1);
                n_acc = w_q_bad ? rspt_pkg::SIGN_ZERO : rspt_pkg::SIGN_POS;
                n_err = w_q_bad;
            end
            rspt_pkg::ST_UPD_CMB: begin
                n_val = rspt_pkg::sign_combine(r_val, i_ram_rdata);
                n_p   = r_p >> 1;
            end
            rspt_pkg::ST_Q_LD: begin
                n_acc = rspt_pkg::sign_combine(r_acc, i_ram_rdata);
                n_l   = r_l + LW'(1);
            end
            rspt_pkg::ST_Q_R: begin
                if (r_r[0]) begin
                    n_r = r_r - LW'(1);
                end else begin
                    n_l = r_l >> 1;
                    n_r = r_r >> 1;
                end
            end
            rspt_pkg::ST_Q_RD: begin
                n_acc = rspt_pkg::sign_combine(r_acc, i_ram_rdata);
                n_l   = r_l >> 1;
                n_r   = r_r >> 1;
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rspt_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_val <= n_val;
        r_l   <= n_l;
        r_r   <= n_r;
        r_acc <= n_acc;
        r_err <= n_err;
    end

    // result holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rspt_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rspt_pkg::ST_DONE && w_out_free) begin
            r_out_sign <= r_acc;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_sign  = r_out_sign;
    assign o_out_err   = r_out_err;

endmodule

[hw/rtl/range_sign_product_tree.sv]
// range sign product tree: a change beat writes its leaf and rebuilds each
// ancestor up to the root through the read-sibling / write-parent loop on
// the single node ram.
// a product beat makes up to two node reads per level through the same read
// port; the result register frees the input as soon as the beat is handed over.
// after reset the node ram is swept to zero with s_tready low; elements_in_use
// resets to 1024.

module range_sign_product_tree #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // position_first[9:0], position_last[19:10],
                                     // new_value[27:20], zero[31:28]
    input  logic        i_s_tuser,   // command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // product_sign[1:0], zero[7:2]
    output logic        o_m_tuser,   // range_error
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int unsigned IW = $clog2(2*MAX_ELEMENTS);

    logic [rspt_pkg::ELEM_W-1:0] w_elements;
    rspt_pkg::t_item             w_item;
    logic [1:0]                  w_sign;
    logic                        w_ram_we;
    logic [IW-1:0]               w_ram_waddr;
    logic [1:0]                  w_ram_wdata;
    logic [IW-1:0]               w_ram_raddr;
    logic [1:0]                  w_ram_rdata;

    // unpack the input beat
    assign w_item.cmd   = i_s_tuser;
    assign w_item.first = i_s_tdata[9:0];
    assign w_item.last  = i_s_tdata[19:10];
    assign w_item.value = i_s_tdata[27:20];

    rspt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .o_elements (w_elements)
    );

    // node sign store
    rspt_ram #(
        .WIDTH (2),
        .DEPTH (2*MAX_ELEMENTS)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    rspt_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_elements  (w_elements),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (w_item),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_sign  (w_sign),
        .o_out_err   (o_m_tuser),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // pack the result beat
    assign o_m_tdata = {6'b0, w_sign};

endmodule

[dv/range_sign_product_tree_tb.sv]
// self-checking testbench for range_sign_product_tree: stream beats, register writes
// and reads, with a scoreboard that predicts range sign products from its own leaf copy
// depends on rspt_pkg and range_sign_product_tree

module range_sign_product_tree_tb;

    localparam int unsigned MAX_ELEMENTS = 1024;
    localparam int unsigned REG_SPARE    = 1;       // index with no register behind it
    localparam int unsigned DRAIN_CYCLES = 64;      // covers two change walks
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 45;
    localparam int unsigned NUM_PHASES   = 10;

    typedef struct {
        logic [1:0] sign;
        logic       err;
    } t_result;

    // scoreboard: leaf signs, register copy and the queue of expected products
    class range_sign_checker;
        logic [1:0]    leaf_sign [MAX_ELEMENTS];
        logic [10:0]   elements;
        t_result       pending [$];
        int unsigned   mismatches;

        function new();
            foreach (leaf_sign[i]) leaf_sign[i] = rspt_pkg::SIGN_ZERO;
            elements   = rspt_pkg::ELEMENTS_RESET;
            mismatches = 0;
        endfunction

        function logic [1:0] combine(input logic [1:0] a, input logic [1:0] b);
            if (a == rspt_pkg::SIGN_ZERO || b == rspt_pkg::SIGN_ZERO) begin
                return rspt_pkg::SIGN_ZERO;
            end
            return (a == b) ? rspt_pkg::SIGN_POS : rspt_pkg::SIGN_NEG;
        endfunction

        // oversized register values clip to the tree size
        function int unsigned in_use();
            return (elements > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elements);
        endfunction

        function void note_config(input int unsigned idx, input logic [31:0] value);
            if (idx == rspt_pkg::REG_ELEMENTS) begin
                elements = value[10:0];
            end
        endfunction

        // called when a beat is accepted at the input
        function void note_command(input rspt_pkg::t_item it);
            t_result     r;
            logic [1:0]  acc;
            int unsigned n;
            int unsigned p;
            n = in_use();
            if (it.cmd == rspt_pkg::CMD_CHANGE) begin
                // out of range changes leave the leaves alone
                if (it.first < n) begin
                    if (it.value == 0) begin
                        leaf_sign[it.first] = rspt_pkg::SIGN_ZERO;
                    end else if (it.value[7]) begin
                        leaf_sign[it.first] = rspt_pkg::SIGN_NEG;
                    end else begin
                        leaf_sign[it.first] = rspt_pkg::SIGN_POS;
                    end
                end
            end else begin
                if (it.first > it.last || it.last >= n) begin
                    r.sign = rspt_pkg::SIGN_ZERO;
                    r.err  = 1'b1;
                end else begin
                    acc = rspt_pkg::SIGN_POS;
                    for (p = it.first; p <= it.last; p++) begin
                        acc = combine(acc, leaf_sign[p]);
                    end
                    r.sign = acc;
                    r.err  = 1'b0;
                end
                pending.push_back(r);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 50) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endtask

        task check_result(input logic [1:0] sign, input logic err);
            t_result want;
            if (pending.size() == 0) begin
                report("result beat with no product pending");
            end else begin
                want = pending.pop_front();
                if (sign !== want.sign) begin
                    report($sformatf("product_sign %0d, expected %0d", sign, want.sign));
                end
                if (err !== want.err) begin
                    report($sformatf("range_error %0b, expected %0b", err, want.err));
                end
            end
        endtask

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // position_first[9:0], position_last[19:10], new_value[27:20]
    logic        i_s_tuser;   // command
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // product_sign[1:0]
    logic        o_m_tuser;   // range_error
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    range_sign_checker sb = new();
    bit                calm;
    int unsigned       cycles;

    range_sign_product_tree #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [9:0] clamp_pos(input int p);
        if (p < 0) begin
            return 10'd0;
        end else if (p > 1023) begin
            return 10'd1023;
        end
        return 10'(p);
    endfunction

    function automatic rspt_pkg::t_item beat_of(input logic cmd, input int first,
                                                input int last, input int value);
        rspt_pkg::t_item it;
        it.cmd   = cmd;
        it.first = clamp_pos(first);
        it.last  = clamp_pos(last);
        it.value = 8'(value);
        return it;
    endfunction

    // random beat, mostly inside a window so products see written signs
    function automatic rspt_pkg::t_item random_beat(input int n, input int base,
                                                    input int span);
        rspt_pkg::t_item it;
        int    a;
        int    b;
        int    tmp;
        int    r;
        it.cmd = ($urandom_range(0, 1) != 0) ? rspt_pkg::CMD_PRODUCT : rspt_pkg::CMD_CHANGE;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            a = base + $urandom_range(0, span - 1);
            b = base + $urandom_range(0, span - 1);
            if (a > b && $urandom_range(0, 99) < 85) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
        end else if (r < 90) begin
            a = $urandom_range(0, 1023);
            b = $urandom_range(0, 1023);
        end else begin
            case ($urandom_range(0, 3))
                0: a = 0;
                1: a = n - 1;
                2: a = n;
                default: a = 1023;
            endcase
            case ($urandom_range(0, 3))
                0: b = 0;
                1: b = n - 1;
                2: b = n;
                default: b = 1023;
            endcase
        end
        it.first = clamp_pos(a);
        it.last  = clamp_pos(b);
        it.value = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
        return it;
    endfunction

    // offer one beat after a random gap and wait for the handshake
    task automatic send_item(input rspt_pkg::t_item it);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {4'b0, it.value, it.last, it.first};
        i_s_tuser  = it.cmd;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        sb.note_command(it);
    endtask

    // sender pauses until every product has come back
    task automatic wait_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.outstanding() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // block idle: no product pending and any trailing change walk finished
    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [31:0] value);
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = 3'(idx * 4);
        i_pwdata  = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) begin
            @(posedge i_clk);
        end
        sb.note_config(idx, value);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    task automatic apb_read_check();
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        i_paddr   = 3'(rspt_pkg::REG_ELEMENTS * 4);
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) begin
            @(posedge i_clk);
        end
        if (o_prdata !== {21'b0, sb.elements}) begin
            sb.report($sformatf("elements_in_use read %0d, expected %0d",
                                o_prdata, sb.elements));
        end
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
    endtask

    // result side: random stalls, one long hold when the calm phase starts
    initial begin
        int unsigned stall_left;
        bit          held;
        stall_left = 0;
        held       = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm && !held) begin
                held       = 1'b1;
                i_m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else begin
                i_m_tready = 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    // result beats checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata[1:0], o_m_tuser);
        end
    end

    // stimulus
    initial begin
        int elem_counts [NUM_PHASES];
        int n;
        int span;
        int base;
        elem_counts  = '{8, 1, 0, 2047, 37, 1024, 3, 600, 1023, 16};
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = rspt_pkg::CMD_CHANGE;
        i_psel       = 1'b0;
        i_penable    = 1'b0;
        i_pwrite     = 1'b0;
        i_paddr      = '0;
        i_pwdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: cleared tree, value extremes, end positions, reversed ranges
        apb_read_check();
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 1023, 0));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 0, 0, 127));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 1, 1023, -128));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 2, 0, -1));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 1023, 1023, 1));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 1022, 0, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 0, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 1, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 1, 2, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 2, -1));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 1023, 1023, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 1022, 1023, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 5, 3, 0));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 1023, 0, 0));
        send_item(beat_of(rspt_pkg::CMD_CHANGE, 3, 0, 64));
        send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 3, 0));

        for (int k = 0; k < NUM_PHASES; k++) begin
            wait_idle();
            if (k == 3) begin
                apb_write(REG_SPARE, $urandom);
            end
            apb_write(rspt_pkg::REG_ELEMENTS, elem_counts[k]);
            apb_read_check();
            n    = sb.in_use();
            span = (n <= 64) ? n + 1 : 16;
            base = (n <= 64) ? 0 : $urandom_range(0, n - span + 1);
            calm = (k == 5);

            // shrunk range: change past the end, range crossing the end
            if (k == 6) begin
                send_item(beat_of(rspt_pkg::CMD_CHANGE, 3, 0, -5));
                send_item(beat_of(rspt_pkg::CMD_PRODUCT, 2, 3, 0));
                send_item(beat_of(rspt_pkg::CMD_PRODUCT, 0, 2, 0));
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (n > 64 && i % 15 == 14) begin
                    base = $urandom_range(0, n - span + 1);
                end
                if (k == 4 && i == 25) begin
                    wait_results();
                end
                send_item(random_beat(n, base, span));
            end
        end

        // drain and settle
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.outstanding() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
